// ----- sv/dmwc_pkg.sv -----
`timescale 1ns / 1ps

package dmwc_pkg;

	localparam int OFFSET_BITS        = 2;
	localparam int INDEX_BITS_DEF     = 6;
	localparam int ADDRESS_BITS_DEF   = 16;
	localparam int ADDR_FIELD_W       = 16;
	localparam int WORD_W             = 32;
	localparam int COUNT_W            = 32;
	localparam int S_TDATA_W          = 48;
	localparam int M_TDATA_W          = 120;

	localparam logic ACT_READ  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic clear_we;
		logic finish;
	} seq_t;

endpackage

// ----- sv/direct_mapped_writeback_cache.sv -----
// Direct-mapped write-back cache, one 32-bit word per line, in front of a backing word
// memory of 2^(ADDRESS_BITS-2) words held inside the block. After reset the block zeroes
// the backing memory, one word per cycle, with s_tready low. After that the accept cycle
// of each beat issues reads of the line memory and of the backing word at the requested
// address; in the lookup state the block then compares the tag and, once the output
// register is free, writes any evicted word back, updates the line and loads the result
// register. The single lookup sequencer holds s_tready low until the lookup is done, so
// no new access is taken before the last one; a result waiting in the output register
// stalls the lookup only when the following result is ready before the first was taken.
`timescale 1ns / 1ps

module direct_mapped_writeback_cache #(
	parameter int INDEX_BITS   = dmwc_pkg::INDEX_BITS_DEF,
	parameter int ADDRESS_BITS = dmwc_pkg::ADDRESS_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// address[15:0], write_data[47:16]
	input  logic [dmwc_pkg::S_TDATA_W-1:0] s_tdata,
	// action[0]
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// read_data[31:0], counted_hit[32], wrote_back[33], evicted_address[49:34],
	// hit_total[81:50], miss_total[113:82], zero[119:114]
	output logic [dmwc_pkg::M_TDATA_W-1:0] m_tdata
);

	import dmwc_pkg::*;

	localparam int WORD_BITS = ADDRESS_BITS - OFFSET_BITS;
	localparam int TAG_BITS  = WORD_BITS - INDEX_BITS;
	localparam int LINES     = 1 << INDEX_BITS;
	localparam int EXT_BITS  = (ADDRESS_BITS > ADDR_FIELD_W) ? ADDRESS_BITS : ADDR_FIELD_W;
	localparam int LINE_W    = TAG_BITS + WORD_W;
	localparam int PAD_W     = M_TDATA_W - (3 * WORD_W + 2 + ADDR_FIELD_W);

	seq_t                  seq;
	logic [WORD_BITS-1:0]  clr_addr;
	logic                  accept;
	logic                  out_busy;

	logic [EXT_BITS-1:0]   addr_ext;
	logic [INDEX_BITS-1:0] idx_in;
	logic [TAG_BITS-1:0]   tag_in;

	logic                  act_s1;
	logic [INDEX_BITS-1:0] idx_s1;
	logic [TAG_BITS-1:0]   tag_s1;
	logic [WORD_W-1:0]     wdata_s1;

	logic [LINES-1:0]      line_valid_q;
	logic [LINE_W-1:0]     line_rd;
	logic [WORD_W-1:0]     back_rd;
	logic                  line_v;
	logic [TAG_BITS-1:0]   line_tag;
	logic [WORD_W-1:0]     line_word;
	logic                  match;
	logic                  hit;
	logic                  wb;
	logic [WORD_W-1:0]     rdata;
	logic [WORD_W-1:0]     new_word;
	logic [EXT_BITS-1:0]   evict_ext;
	logic [ADDR_FIELD_W-1:0] evict_addr;

	logic                  back_we;
	logic [WORD_BITS-1:0]  back_waddr;
	logic [WORD_W-1:0]     back_wdata;

	logic [COUNT_W-1:0]    hit_q;
	logic [COUNT_W-1:0]    miss_q;
	logic [COUNT_W-1:0]    hit_next;
	logic [COUNT_W-1:0]    miss_next;
	logic                  m_tvalid_q;
	logic [M_TDATA_W-1:0]  m_tdata_q;

	assign accept   = s_tvalid & seq.in_ready;
	assign out_busy = m_tvalid_q & ~m_tready;
	assign s_tready = seq.in_ready;

	dmwc_seq #(
		.WORD_BITS(WORD_BITS)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.out_busy(out_busy),
		.seq     (seq),
		.clr_addr(clr_addr)
	);

	assign addr_ext = EXT_BITS'(s_tdata[ADDR_FIELD_W-1:0]);
	assign idx_in   = addr_ext[OFFSET_BITS +: INDEX_BITS];
	assign tag_in   = addr_ext[OFFSET_BITS + INDEX_BITS +: TAG_BITS];

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1   <= s_tuser;
			idx_s1   <= idx_in;
			tag_s1   <= tag_in;
			wdata_s1 <= s_tdata[ADDR_FIELD_W +: WORD_W];
		end
	end

	dmwc_ram #(
		.WIDTH(LINE_W),
		.DEPTH(LINES)
	) u_line_ram (
		.clk  (clk),
		.we   (seq.finish),
		.waddr(idx_s1),
		.wdata({tag_s1, new_word}),
		.re   (accept),
		.raddr(idx_in),
		.rdata(line_rd)
	);

	assign back_we    = seq.clear_we | (seq.finish & wb);
	assign back_waddr = seq.clear_we ? clr_addr : {line_tag, idx_s1};
	assign back_wdata = seq.clear_we ? '0 : line_word;

	dmwc_ram #(
		.WIDTH(WORD_W),
		.DEPTH(1 << WORD_BITS)
	) u_back_ram (
		.clk  (clk),
		.we   (back_we),
		.waddr(back_waddr),
		.wdata(back_wdata),
		.re   (accept),
		.raddr({tag_in, idx_in}),
		.rdata(back_rd)
	);

	assign line_v    = line_valid_q[idx_s1];
	assign line_tag  = line_v ? line_rd[WORD_W +: TAG_BITS] : '0;
	assign line_word = line_rd[WORD_W-1:0];
	assign match     = (line_tag == tag_s1);
	assign wb        = line_v & ~match;
	assign hit       = (act_s1 == ACT_WRITE) ? (match | ~line_v) : (line_v & match);

	always_comb begin
		priority if (act_s1 == ACT_WRITE) begin
			rdata    = '0;
			new_word = wdata_s1;
		end else if (hit) begin
			rdata    = line_word;
			new_word = line_word;
		end else begin
			rdata    = back_rd;
			new_word = back_rd;
		end
	end

	assign evict_ext  = wb ? EXT_BITS'({line_tag, idx_s1, {OFFSET_BITS{1'b0}}}) : '0;
	assign evict_addr = evict_ext[ADDR_FIELD_W-1:0];
	assign hit_next   = hit_q + COUNT_W'(hit);
	assign miss_next  = miss_q + COUNT_W'(!hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_valid_q <= '0;
			hit_q        <= '0;
			miss_q       <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (seq.finish) begin
				line_valid_q[idx_s1] <= 1'b1;
				hit_q                <= hit_next;
				miss_q               <= miss_next;
				m_tvalid_q           <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (seq.finish) begin
			m_tdata_q <= {{PAD_W{1'b0}}, miss_next, hit_next, evict_addr, wb, hit, rdata};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ----- sv/dmwc_ram.sv -----
`timescale 1ns / 1ps

module dmwc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/dmwc_seq.sv -----
`timescale 1ns / 1ps

module dmwc_seq #(
	parameter int WORD_BITS = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 out_busy,
	output dmwc_pkg::seq_t       seq,
	output logic [WORD_BITS-1:0] clr_addr
);

	import dmwc_pkg::*;

	state_t               state_q;
	state_t               state_d;
	logic [WORD_BITS-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + WORD_BITS'(1);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		seq     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				seq.clear_we = 1'b1;
				if (&clr_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				seq.in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (!out_busy) begin
					seq.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign clr_addr = clr_q;

endmodule

// ----- sv/dmwc_checker.sv -----
`timescale 1ns / 1ps

module dmwc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [dmwc_pkg::S_TDATA_W-1:0] s_tdata,
	input logic                           s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [dmwc_pkg::M_TDATA_W-1:0] m_tdata
);

	import dmwc_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second beat accepted during lookup");

	a_wb_is_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[33] |-> !m_tdata[32])
		else $error("write-back reported on a hit");

	a_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[33] |-> m_tdata[49:34] == '0)
		else $error("eviction address without write-back");

endmodule

bind direct_mapped_writeback_cache dmwc_checker u_dmwc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
